>>> rtl/core/csv_byte_tokenizer_macros.svh
// Assertion macros for the CSV tokenizer RTL.
// Include with the bare file name; the bodies compile away under SYNTHESIS.
`ifndef CSV_BYTE_TOKENIZER_MACROS_SVH
`define CSV_BYTE_TOKENIZER_MACROS_SVH

`ifndef SYNTHESIS

// Check a plain property on every clock edge outside reset.
`define CSVT_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error(msg);

// Check that the antecedent implies the consequent in the same cycle.
`define CSVT_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Check that the antecedent implies the consequent in the following cycle.
`define CSVT_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CSVT_ASSERT(name, clk, rstn, prop, msg)
`define CSVT_ASSERT_IMP(name, clk, rstn, ante, cons, msg)
`define CSVT_ASSERT_NEXT(name, clk, rstn, ante, cons, msg)

`endif

`endif

>>> rtl/core/csvt_pkg.sv
// Shared types, character constants and the byte classifier of the CSV tokenizer.
// No dependencies; imported by every module of the block.
`default_nettype none

package csvt_pkg;

  // Input operation codes
  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Special characters
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] BOM_A    = 8'hEF;
  localparam logic [7:0] BOM_B    = 8'hBB;
  localparam logic [7:0] BOM_C    = 8'hBF;

  // Token kinds
  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_FEND = 2'd1,
    KIND_REND = 2'd2,
    KIND_EOI  = 2'd3
  } kind_e;

  // Byte class flags
  typedef struct packed {
    logic delim;
    logic cr;
    logic lf;
    logic quote;
    logic bom_a;
    logic bom_b;
    logic bom_c;
  } cls_t;

  // Classified input word as it travels through the queue
  typedef struct packed {
    logic       op;
    logic [7:0] data;
    cls_t       cls;
  } item_t;

  // One output token
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       chunk;
    logic       last;
  } token_t;

  // Configuration seen by front and back
  typedef struct packed {
    logic [7:0]  delim;
    logic [31:0] limit;
  } cfg_t;

  function automatic cls_t classify(input logic [7:0] b, input logic [7:0] delim);
    cls_t c;
    c.delim = (b == delim);
    c.cr    = (b == CH_CR);
    c.lf    = (b == CH_LF);
    c.quote = (b == CH_QUOTE);
    c.bom_a = (b == BOM_A);
    c.bom_b = (b == BOM_B);
    c.bom_c = (b == BOM_C);
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/csv_byte_tokenizer.sv
// Top level of the CSV byte tokenizer: configuration registers, front, queue and engine.
// Depends on csvt_pkg, csvt_front, csvt_queue and csvt_back.
//
// The block takes one CSV byte (or an end-of-input flush) per input word and emits tokens:
// field bytes, field ends, row ends (one closed by a line feed has a chunk mark once the
// byte count passes chunk_limit) and end of input, the final token of each word flagged by
// last. The token engine carries out one action per cycle while its token has room in the
// hold stage, and each action yields at most one token: a plain byte or a word that yields
// nothing is one action, a row end is an action of its own after its field end, a byte
// after a held CR gives the CR, then the byte, a BOM mismatch adds a setup action before
// the replayed bytes, and a flush replays pending bytes, closes an open row and ends the
// input. The four-entry queue between the input stage and the engine absorbs bursts, and
// the one-word hold stage in front of the output register lets the engine decide the last
// flag without a bubble.
// Configuration registers are written through a port that is always ready; write them only
// while the block is idle.
`default_nettype none

module csv_byte_tokenizer
  import csvt_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input channel
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic        op_i,
  input  wire logic [7:0]  in_byte_i,
  // Output channel
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [1:0]  kind_o,
  output      logic [7:0]  out_byte_o,
  output      logic        chunk_end_o,
  output      logic        last_o,
  // Configuration write channel
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [3:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  localparam logic [3:0]  CFG_FIELD_DELIM = 4'd0;
  localparam logic [3:0]  CFG_CHUNK_LIMIT = 4'd1;
  localparam logic [7:0]  DelimReset      = 8'd44;
  localparam logic [31:0] LimitReset      = 32'hFFFF_FFFF;

  cfg_t   cfg_q;
  logic   q_full;
  logic   q_push;
  item_t  q_in;
  logic   q_valid;
  item_t  q_head;
  logic   q_pop;
  token_t out_tok;

  assign cfg_ready_o = 1'b1;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delim <= DelimReset;
      cfg_q.limit <= LimitReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_FIELD_DELIM: cfg_q.delim <= cfg_data_i[7:0];
        CFG_CHUNK_LIMIT: cfg_q.limit <= cfg_data_i;
        default: ;
      endcase
    end
  end

  csvt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .in_byte_i  (in_byte_i),
    .delim_i    (cfg_q.delim),
    .full_i     (q_full),
    .push_o     (q_push),
    .item_o     (q_in)
  );

  csvt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_head)
  );

  csvt_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_item_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_tok_o   (out_tok)
  );

  assign kind_o      = out_tok.kind;
  assign out_byte_o  = out_tok.data;
  assign chunk_end_o = out_tok.chunk;
  assign last_o      = out_tok.last;

endmodule

`default_nettype wire

>>> rtl/core/csvt_front.sv
// Input stage of the CSV tokenizer: accepts words and tags each byte with its class.
// Depends on csvt_pkg; feeds csvt_queue.
`default_nettype none

module csvt_front
  import csvt_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output      logic       in_stall_o,
  input  wire logic       op_i,
  input  wire logic [7:0] in_byte_i,
  input  wire logic [7:0] delim_i,
  input  wire logic       full_i,
  output      logic       push_o,
  output      item_t      item_o
);

  logic  stg_v_q;
  item_t stg_q;
  logic  accept;

  // Stall only while the stage is loaded and the queue cannot take it
  assign push_o     = stg_v_q && !full_i;
  assign in_stall_o = stg_v_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign item_o     = stg_q;

  // Capture and classify the incoming word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_v_q <= 1'b0;
      stg_q   <= '0;
    end else begin
      if (accept) begin
        stg_v_q    <= 1'b1;
        stg_q.op   <= op_i;
        stg_q.data <= in_byte_i;
        stg_q.cls  <= classify(in_byte_i, delim_i);
      end else if (push_o) begin
        stg_v_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/csvt_queue.sv
// Short register queue between the classifying front and the token engine.
// Depends on csvt_pkg for the item type.
`default_nettype none

module csvt_queue
  import csvt_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t item_i,
  output      logic  full_o,
  input  wire logic  pop_i,
  output      logic  valid_o,
  output      item_t item_o
);

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  item_t            mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q;
  logic [QPtrW-1:0] rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [QPtrW-1:0] ptr_next(input logic [QPtrW-1:0] p);
    return (p == QPtrW'(QDepth - 1)) ? '0 : p + QPtrW'(1);
  endfunction

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/csvt_back.sv
// Token engine of the CSV tokenizer: parse state, byte count, action list and output.
// Depends on csvt_pkg and the assertion macros; takes items from csvt_queue.
`default_nettype none
`include "csv_byte_tokenizer_macros.svh"

module csvt_back
  import csvt_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire cfg_t   cfg_i,
  input  wire logic   q_valid_i,
  input  wire item_t  q_item_i,
  output      logic   q_pop_o,
  output      logic   out_valid_o,
  input  wire logic   out_stall_i,
  output      token_t out_tok_o
);

  localparam int NumSlots = 4;
  localparam int CmpW     = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

  typedef enum logic [2:0] {
    MODE_UNQ,
    MODE_INQ,
    MODE_QSEEN,
    MODE_CRSEEN,
    MODE_BOM1,
    MODE_BOM2
  } mode_e;

  typedef enum logic [1:0] {
    ACT_CU,
    ACT_UNQ,
    ACT_CLOSE,
    ACT_EOI
  } act_e;

  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_ROW,
    SRC_SLOT,
    SRC_ITEM
  } src_e;

  typedef struct packed {
    act_e       act;
    logic [7:0] data;
    cls_t       cls;
  } slot_t;

  // Parse state
  mode_e                  mode_q, mode_d;
  logic                   afs_q, afs_d;
  logic                   rhf_q, rhf_d;
  logic                   fhb_q, fhb_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic                   row_pend_q, row_pend_d;
  logic                   row_chk_q, row_chk_d;
  slot_t                  slot_q [NumSlots];
  slot_t                  slot_d [NumSlots];
  logic [NumSlots-1:0]    slot_v_q, slot_v_d;

  // Token hold and output registers
  logic   hold_v_q;
  logic   hold_rel_q;
  token_t hold_q;
  logic   out_v_q;
  token_t out_q;

  src_e       src;
  logic [7:0] sel_data;
  cls_t       sel_cls;
  cls_t       cls_ea;
  cls_t       cls_eb;
  logic       emit;
  token_t     tok;
  logic       do_cnt;
  logic       do_unq;
  logic       done;
  logic       out_free;
  logic       emit_ok;
  logic       fire;
  logic       tok_fire;
  logic       hold_move;
  logic [CmpW-1:0] cnt_ext;
  logic [CmpW-1:0] lim_ext;

  assign cls_ea  = classify(BOM_A, cfg_i.delim);
  assign cls_eb  = classify(BOM_B, cfg_i.delim);
  assign cnt_ext = CmpW'(count_q);
  assign lim_ext = CmpW'(cfg_i.limit);

  // Pick the next action: pending row end, queued replay, then a new word
  always_comb begin
    src = SRC_NONE;
    if (row_pend_q) begin
      src = SRC_ROW;
    end else if (slot_v_q[0]) begin
      src = SRC_SLOT;
    end else if (q_valid_i) begin
      src = SRC_ITEM;
    end
  end

  assign sel_data = (src == SRC_SLOT) ? slot_q[0].data : q_item_i.data;
  assign sel_cls  = (src == SRC_SLOT) ? slot_q[0].cls  : q_item_i.cls;

  // Work out one action: its token and the next parse state
  always_comb begin
    mode_d     = mode_q;
    afs_d      = afs_q;
    rhf_d      = rhf_q;
    fhb_d      = fhb_q;
    count_d    = count_q;
    row_pend_d = row_pend_q;
    row_chk_d  = row_chk_q;
    slot_d     = slot_q;
    slot_v_d   = slot_v_q;
    emit       = 1'b0;
    tok        = '{kind: KIND_BYTE, data: 8'h00, chunk: 1'b0, last: 1'b0};
    do_cnt     = 1'b0;
    do_unq     = 1'b0;

    case (src)
      SRC_ROW: begin
        emit       = 1'b1;
        tok.kind   = KIND_REND;
        tok.chunk  = row_chk_q && (cnt_ext > lim_ext);
        if (tok.chunk) begin
          count_d = '0;
        end
        rhf_d      = 1'b0;
        fhb_d      = 1'b0;
        row_pend_d = 1'b0;
      end

      SRC_SLOT: begin
        for (int i = 0; i < NumSlots - 1; i++) begin
          slot_d[i] = slot_q[i+1];
        end
        slot_v_d = {1'b0, slot_v_q[NumSlots-1:1]};
        case (slot_q[0].act)
          ACT_CU: begin
            do_cnt = 1'b1;
            do_unq = 1'b1;
          end
          ACT_UNQ: begin
            do_unq = 1'b1;
          end
          ACT_CLOSE: begin
            if (rhf_q || fhb_q) begin
              emit       = 1'b1;
              tok.kind   = KIND_FEND;
              row_pend_d = 1'b1;
              row_chk_d  = 1'b0;
            end
          end
          ACT_EOI: begin
            emit     = 1'b1;
            tok.kind = KIND_EOI;
            mode_d   = MODE_UNQ;
            afs_d    = 1'b1;
            rhf_d    = 1'b0;
            fhb_d    = 1'b0;
            count_d  = '0;
          end
          default: ;
        endcase
      end

      SRC_ITEM: begin
        if (q_item_i.op == OP_FLUSH) begin
          // Replay what is pending, then close an open row and end the input
          mode_d = MODE_UNQ;
          case (mode_q)
            MODE_BOM1: begin
              slot_d[0] = '{act: ACT_CU, data: BOM_A, cls: cls_ea};
              slot_d[1] = '{act: ACT_CLOSE, data: 8'h00, cls: '0};
              slot_d[2] = '{act: ACT_EOI, data: 8'h00, cls: '0};
              slot_v_d  = NumSlots'(4'b0111);
            end
            MODE_BOM2: begin
              slot_d[0] = '{act: ACT_CU, data: BOM_A, cls: cls_ea};
              slot_d[1] = '{act: ACT_CU, data: BOM_B, cls: cls_eb};
              slot_d[2] = '{act: ACT_CLOSE, data: 8'h00, cls: '0};
              slot_d[3] = '{act: ACT_EOI, data: 8'h00, cls: '0};
              slot_v_d  = NumSlots'(4'b1111);
            end
            MODE_CRSEEN: begin
              emit      = 1'b1;
              tok.data  = CH_CR;
              fhb_d     = 1'b1;
              slot_d[0] = '{act: ACT_CLOSE, data: 8'h00, cls: '0};
              slot_d[1] = '{act: ACT_EOI, data: 8'h00, cls: '0};
              slot_v_d  = NumSlots'(4'b0011);
            end
            default: begin
              slot_d[0] = '{act: ACT_CLOSE, data: 8'h00, cls: '0};
              slot_d[1] = '{act: ACT_EOI, data: 8'h00, cls: '0};
              slot_v_d  = NumSlots'(4'b0011);
            end
          endcase
        end else begin
          case (mode_q)
            MODE_INQ: begin
              do_cnt = 1'b1;
              if (q_item_i.cls.quote) begin
                mode_d = MODE_QSEEN;
              end else begin
                emit     = 1'b1;
                tok.data = q_item_i.data;
                fhb_d    = 1'b1;
              end
            end
            MODE_QSEEN: begin
              do_cnt = 1'b1;
              if (q_item_i.cls.quote) begin
                emit     = 1'b1;
                tok.data = CH_QUOTE;
                fhb_d    = 1'b1;
                mode_d   = MODE_INQ;
              end else begin
                mode_d = MODE_UNQ;
                do_unq = 1'b1;
              end
            end
            MODE_CRSEEN: begin
              do_cnt = 1'b1;
              mode_d = MODE_UNQ;
              if (q_item_i.cls.lf) begin
                emit       = 1'b1;
                tok.kind   = KIND_FEND;
                row_pend_d = 1'b1;
                row_chk_d  = 1'b1;
              end else begin
                // The held CR is data; parse this byte afterwards
                emit      = 1'b1;
                tok.data  = CH_CR;
                fhb_d     = 1'b1;
                slot_d[0] = '{act: ACT_UNQ, data: q_item_i.data, cls: q_item_i.cls};
                slot_v_d  = NumSlots'(4'b0001);
              end
            end
            MODE_BOM1: begin
              if (q_item_i.cls.bom_b) begin
                mode_d = MODE_BOM2;
              end else begin
                mode_d    = MODE_UNQ;
                slot_d[0] = '{act: ACT_CU, data: BOM_A, cls: cls_ea};
                slot_d[1] = '{act: ACT_CU, data: q_item_i.data, cls: q_item_i.cls};
                slot_v_d  = NumSlots'(4'b0011);
              end
            end
            MODE_BOM2: begin
              mode_d = MODE_UNQ;
              if (!q_item_i.cls.bom_c) begin
                slot_d[0] = '{act: ACT_CU, data: BOM_A, cls: cls_ea};
                slot_d[1] = '{act: ACT_CU, data: BOM_B, cls: cls_eb};
                slot_d[2] = '{act: ACT_CU, data: q_item_i.data, cls: q_item_i.cls};
                slot_v_d  = NumSlots'(4'b0111);
              end
            end
            default: begin
              mode_d = MODE_UNQ;
              afs_d  = 1'b0;
              if (afs_q && q_item_i.cls.bom_a) begin
                mode_d = MODE_BOM1;
              end else begin
                do_cnt = 1'b1;
                do_unq = 1'b1;
              end
            end
          endcase
        end
      end

      default: ;
    endcase

    // Count the byte, saturating at the top of the counter
    if (do_cnt && (count_q != '1)) begin
      count_d = count_q + COUNT_WIDTH'(1);
    end

    // Parse a byte outside quotes; the delimiter is tested first
    if (do_unq) begin
      if (sel_cls.delim) begin
        emit     = 1'b1;
        tok.kind = KIND_FEND;
        rhf_d    = 1'b1;
        fhb_d    = 1'b0;
      end else if (sel_cls.cr) begin
        mode_d = MODE_CRSEEN;
      end else if (sel_cls.lf) begin
        emit       = 1'b1;
        tok.kind   = KIND_FEND;
        rhf_d      = 1'b1;
        fhb_d      = 1'b0;
        row_pend_d = 1'b1;
        row_chk_d  = 1'b1;
      end else if (sel_cls.quote) begin
        mode_d = MODE_INQ;
      end else begin
        emit     = 1'b1;
        tok.kind = KIND_BYTE;
        tok.data = sel_data;
        fhb_d    = 1'b1;
      end
    end
  end

  // Fire when the token, if any, has room in the hold register
  assign done      = !row_pend_d && !slot_v_d[0];
  assign out_free  = !out_v_q || !out_stall_i;
  assign emit_ok   = !hold_v_q || out_free;
  assign fire      = (src != SRC_NONE) && (!emit || emit_ok);
  assign tok_fire  = fire && emit;
  assign hold_move = hold_v_q && out_free && (hold_rel_q || tok_fire);
  assign q_pop_o   = fire && (src == SRC_ITEM);

  assign out_valid_o = out_v_q;
  assign out_tok_o   = out_q;

  // Hold parse state, the token hold stage and the output word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_UNQ;
      afs_q      <= 1'b1;
      rhf_q      <= 1'b0;
      fhb_q      <= 1'b0;
      count_q    <= '0;
      row_pend_q <= 1'b0;
      row_chk_q  <= 1'b0;
      slot_v_q   <= '0;
      for (int i = 0; i < NumSlots; i++) begin
        slot_q[i] <= '0;
      end
      hold_v_q   <= 1'b0;
      hold_rel_q <= 1'b0;
      hold_q     <= '0;
      out_v_q    <= 1'b0;
      out_q      <= '0;
    end else begin
      if (fire) begin
        mode_q     <= mode_d;
        afs_q      <= afs_d;
        rhf_q      <= rhf_d;
        fhb_q      <= fhb_d;
        count_q    <= count_d;
        row_pend_q <= row_pend_d;
        row_chk_q  <= row_chk_d;
        slot_v_q   <= slot_v_d;
        slot_q     <= slot_d;
      end

      // Move the hold word out once its last flag is known
      if (hold_move) begin
        out_v_q <= 1'b1;
        out_q   <= hold_q;
      end else if (out_v_q && !out_stall_i) begin
        out_v_q <= 1'b0;
      end

      if (tok_fire) begin
        hold_v_q   <= 1'b1;
        hold_rel_q <= done;
        hold_q     <= '{kind: tok.kind, data: tok.data, chunk: tok.chunk, last: done};
      end else if (hold_move) begin
        hold_v_q <= 1'b0;
      end else if (fire && done && hold_v_q && !hold_rel_q) begin
        hold_rel_q  <= 1'b1;
        hold_q.last <= 1'b1;
      end
    end
  end

  `CSVT_ASSERT_IMP(a_hold_open_busy, clk_i, rst_ni, hold_v_q && !hold_rel_q, row_pend_q || slot_v_q[0], "open hold word without work in progress")
  `CSVT_ASSERT_IMP(a_row_after_fend, clk_i, rst_ni, row_pend_q, hold_v_q && !hold_rel_q && (hold_q.kind == KIND_FEND), "row end pending without a held field end")
  `CSVT_ASSERT(a_slots_packed, clk_i, rst_ni, (slot_v_q & (slot_v_q + NumSlots'(1))) == '0, "action list has a gap")
  `CSVT_ASSERT_NEXT(a_open_token_held, clk_i, rst_ni, tok_fire && !done, hold_v_q && !hold_rel_q, "non-final token not held open")
  `CSVT_ASSERT_IMP(a_eoi_is_last, clk_i, rst_ni, out_v_q && (out_q.kind == KIND_EOI), out_q.last, "end of input not marked last")

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// Self-checking bench for csv_byte_tokenizer: directed table, then random CSV streams.
// Depends on csvt_pkg for token kinds, op codes and character constants.
`default_nettype none

module tb_top;
  import csvt_pkg::*;

  localparam int IDLE_LIMIT      = 2000;
  localparam int DRAIN_PAUSE     = 40;
  localparam int ITEMS_PER_PHASE = 32;
  localparam int N_PHASES        = 8;
  localparam int MAX_TOKENS      = 5;
  localparam logic [3:0] REG_DELIM = 4'd0;
  localparam logic [3:0] REG_LIMIT = 4'd1;
  localparam int REG_COUNT       = 2;

  typedef enum logic [2:0] {
    PM_PLAIN, PM_QUOTED, PM_QUOTE_SEEN, PM_CR_SEEN, PM_BOM1, PM_BOM2
  } parse_mode_e;

  typedef struct packed {
    logic       op;
    logic [7:0] b;
    logic       pinned;
    kind_e      kind;
    logic [7:0] data;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        op = OP_DATA;
  logic [7:0]  in_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  out_byte;
  logic        chunk_end;
  logic        last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_index = 4'd0;
  logic [31:0] cfg_data = 32'd0;

  csv_byte_tokenizer uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .op_i        (op),
    .in_byte_i   (in_byte),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .kind_o      (kind),
    .out_byte_o  (out_byte),
    .chunk_end_o (chunk_end),
    .last_o      (last),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Tokenizer shadow: registers and parse state
  logic [7:0]  cur_delim = 8'd44;
  logic [31:0] cur_limit = 32'hFFFF_FFFF;
  parse_mode_e pm = PM_PLAIN;
  logic        at_start = 1'b1;
  logic        row_open = 1'b0;
  logic        field_open = 1'b0;
  logic [31:0] byte_count = 32'd0;

  token_t step_toks[$];
  token_t tokens_due[$];

  int  n_fail = 0;
  int  idle_cycles = 0;
  int  out_wait = 0;
  bit  in_quiet = 1'b0;
  bit  out_quiet = 1'b0;
  token_t want;

  function automatic void push_tok(kind_e k, logic [7:0] d, logic c);
    token_t t;
    t.kind = k;
    t.data = d;
    t.chunk = c;
    t.last = 1'b0;
    if (step_toks.size() < MAX_TOKENS) step_toks = {step_toks, t};
  endfunction

  function automatic void bump_count();
    if (~&byte_count) byte_count = byte_count + 32'd1;
  endfunction

  function automatic void end_field();
    push_tok(KIND_FEND, 8'h00, 1'b0);
    row_open = 1'b1;
    field_open = 1'b0;
  endfunction

  // Close the row; a counted row end past the limit marks the chunk and restarts the count
  function automatic void end_row(logic check);
    logic c;
    c = 1'b0;
    push_tok(KIND_FEND, 8'h00, 1'b0);
    if (check && byte_count > cur_limit) begin
      c = 1'b1;
      byte_count = 32'd0;
    end
    push_tok(KIND_REND, 8'h00, c);
    row_open = 1'b0;
    field_open = 1'b0;
  endfunction

  function automatic void field_byte(logic [7:0] b);
    push_tok(KIND_BYTE, b, 1'b0);
    field_open = 1'b1;
  endfunction

  // Unquoted byte: delimiter wins over CR, LF and quote
  function automatic void plain_byte(logic [7:0] b);
    if (b == cur_delim) end_field();
    else if (b == CH_CR) pm = PM_CR_SEEN;
    else if (b == CH_LF) end_row(1'b1);
    else if (b == CH_QUOTE) pm = PM_QUOTED;
    else field_byte(b);
  endfunction

  function automatic void counted_plain(logic [7:0] b);
    bump_count();
    plain_byte(b);
  endfunction

  function automatic void clear_parse();
    pm = PM_PLAIN;
    at_start = 1'b1;
    row_open = 1'b0;
    field_open = 1'b0;
    byte_count = 32'd0;
  endfunction

  // Work out the tokens of one accepted word into step_toks
  function automatic void predict_tokens(logic w_op, logic [7:0] b);
    token_t t;
    step_toks.delete();
    if (w_op == OP_DATA) begin
      case (pm)
        PM_QUOTED: begin
          bump_count();
          if (b == CH_QUOTE) pm = PM_QUOTE_SEEN;
          else field_byte(b);
        end
        PM_QUOTE_SEEN: begin
          bump_count();
          if (b == CH_QUOTE) begin
            field_byte(CH_QUOTE);
            pm = PM_QUOTED;
          end else begin
            pm = PM_PLAIN;
            plain_byte(b);
          end
        end
        PM_CR_SEEN: begin
          bump_count();
          pm = PM_PLAIN;
          if (b == CH_LF) begin
            end_row(1'b1);
          end else begin
            field_byte(CH_CR);
            plain_byte(b);
          end
        end
        PM_BOM1: begin
          if (b == BOM_B) begin
            pm = PM_BOM2;
          end else begin
            pm = PM_PLAIN;
            counted_plain(BOM_A);
            counted_plain(b);
          end
        end
        PM_BOM2: begin
          pm = PM_PLAIN;
          if (b != BOM_C) begin
            counted_plain(BOM_A);
            counted_plain(BOM_B);
            counted_plain(b);
          end
        end
        default: begin
          pm = PM_PLAIN;
          if (at_start && b == BOM_A) begin
            at_start = 1'b0;
            pm = PM_BOM1;
          end else begin
            at_start = 1'b0;
            counted_plain(b);
          end
        end
      endcase
    end else begin
      // Flush: replay pending bytes, close an open row, then end of input
      if (pm == PM_BOM1) begin
        pm = PM_PLAIN;
        counted_plain(BOM_A);
      end else if (pm == PM_BOM2) begin
        pm = PM_PLAIN;
        counted_plain(BOM_A);
        counted_plain(BOM_B);
      end else if (pm == PM_CR_SEEN) begin
        field_byte(CH_CR);
      end
      if (row_open || field_open) end_row(1'b0);
      push_tok(KIND_EOI, 8'h00, 1'b0);
      clear_parse();
    end
    if (step_toks.size() > 0) begin
      t = step_toks.pop_back();
      t.last = 1'b1;
      step_toks = {step_toks, t};
    end
  endfunction

  // Drive one input word after a random gap (none while input is quiet) and queue its tokens once accepted
  task automatic drive_word(input logic w_op, input logic [7:0] b, input logic pinned,
                            input token_t pin_tok);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= w_op;
    in_byte <= b;
    do @(posedge clk); while (in_stall);
    predict_tokens(w_op, b);
    if (pinned) tokens_due = {tokens_due, pin_tok};
    else tokens_due = {tokens_due, step_toks};
  endtask

  task automatic send_byte(input logic [7:0] b);
    drive_word(OP_DATA, b, 1'b0, '0);
  endtask

  // Raise a config write and hold it until taken; the caller drops valid
  task automatic write_reg(input logic [3:0] idx, input logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_DELIM) cur_delim = d[7:0];
    else if (idx == REG_LIMIT) cur_limit = d;
  endtask

  // Wait until every token has arrived, then let the engine settle
  task automatic drain();
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  function automatic logic [7:0] noise_byte();
    int unsigned r;
    logic [7:0] v;
    r = $urandom_range(0, 99);
    v = 8'($urandom_range(0, 255));
    if (r < 40) v = 8'h61 + 8'($urandom_range(0, 25));
    else if (r < 55) v = cur_delim;
    else if (r < 63) v = CH_QUOTE;
    else if (r < 70) v = CH_LF;
    else if (r < 76) v = CH_CR;
    else if (r < 80) v = BOM_A;
    else if (r < 83) v = BOM_B;
    else if (r < 86) v = BOM_C;
    return v;
  endfunction

  // Check each taken token against the oldest expectation, then draw the next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (tokens_due.size() == 0) begin
        $error("token with nothing expected: kind %0d byte %02h", kind, out_byte);
        n_fail++;
      end else begin
        want = tokens_due.pop_front();
        if (kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, kind);
          n_fail++;
        end
        if (out_byte !== want.data) begin
          $error("out_byte: expected %02h, got %02h", want.data, out_byte);
          n_fail++;
        end
        if (chunk_end !== want.chunk) begin
          $error("chunk_end: expected %0d, got %0d", want.chunk, chunk_end);
          n_fail++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last);
          n_fail++;
        end
      end
      out_wait = out_quiet ? 0 : $urandom_range(0, 19);
      out_stall <= (out_wait > 0);
    end else if (out_wait > 0) begin
      out_wait = out_wait - 1;
      if (out_wait == 0) out_stall <= 1'b0;
    end
  end

  // Count cycles in which no word moves on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin : watchdog
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    stim_row_t   dir_tab [29];
    token_t      pin;
    logic [7:0]  phase_delim [N_PHASES];
    logic [31:0] phase_limit [N_PHASES];
    int          n_sent;
    int          k;
    int unsigned r;

    // Directed rows at reset settings; pinned rows carry their one typed token
    dir_tab = '{
      '{OP_FLUSH, 8'h00, 1'b1, KIND_EOI,  8'h00},
      '{OP_DATA,  8'h61, 1'b1, KIND_BYTE, 8'h61},
      '{OP_DATA,  8'h00, 1'b1, KIND_BYTE, 8'h00},
      '{OP_DATA,  8'hFF, 1'b1, KIND_BYTE, 8'hFF},
      '{OP_DATA,  8'h2C, 1'b1, KIND_FEND, 8'h00},
      '{OP_DATA,  8'h22, 1'b0, KIND_BYTE, 8'h00},
      '{OP_DATA,  8'h2C, 1'b0, KIND_BYTE, 8'h00},
      '{OP_DATA,  8'h22, 1'b0, KIND_BYTE, 8'h00},
      '{OP_DATA,  8'h22, 1'b0, KIND_BYTE, 8'h00},
      '{OP_DATA,  8'h22, 1'b0, KIND_BYTE, 8'h00},
      '{OP_DATA,  8'h78, 1'b0, KIND_BYTE, 8'h00},
      '{OP_DATA,  8'h0D, 1'b0, KIND_BYTE, 8'h00},
      '{OP_DATA,  8'h0A, 1'b0, KIND_BYTE, 8'h00},
      '{OP_DATA,  8'h0D, 1'b0, KIND_BYTE, 8'h00},
      '{OP_DATA,  8'h62, 1'b0, KIND_BYTE, 8'h00},
      '{OP_DATA,  8'h0D, 1'b0, KIND_BYTE, 8'h00},
      '{OP_FLUSH, 8'hA5, 1'b0, KIND_BYTE, 8'h00},
      '{OP_DATA,  8'hEF, 1'b0, KIND_BYTE, 8'h00},
      '{OP_DATA,  8'hBB, 1'b0, KIND_BYTE, 8'h00},
      '{OP_DATA,  8'hBF, 1'b0, KIND_BYTE, 8'h00},
      '{OP_DATA,  8'h2C, 1'b0, KIND_BYTE, 8'h00},
      '{OP_FLUSH, 8'hFF, 1'b0, KIND_BYTE, 8'h00},
      '{OP_DATA,  8'hEF, 1'b0, KIND_BYTE, 8'h00},
      '{OP_DATA,  8'h64, 1'b0, KIND_BYTE, 8'h00},
      '{OP_DATA,  8'h22, 1'b0, KIND_BYTE, 8'h00},
      '{OP_FLUSH, 8'h00, 1'b0, KIND_BYTE, 8'h00},
      '{OP_DATA,  8'hEF, 1'b0, KIND_BYTE, 8'h00},
      '{OP_DATA,  8'hBB, 1'b0, KIND_BYTE, 8'h00},
      '{OP_FLUSH, 8'h5A, 1'b0, KIND_BYTE, 8'h00}
    };
    phase_delim = '{8'h2C, 8'h09, CH_QUOTE, CH_CR, CH_LF, 8'h00, 8'hFF, 8'h3B};
    phase_limit = '{32'hFFFF_FFFF, 32'd0, 32'd5, 32'd20, 32'd3, 32'd1, 32'd64, 32'd12};
    phase_delim[N_PHASES-1] = 8'($urandom_range(0, 255));
    phase_limit[N_PHASES-1] = $urandom_range(0, 40);

    // Hold reset, then release it
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      pin.kind = dir_tab[i].kind;
      pin.data = dir_tab[i].data;
      pin.chunk = 1'b0;
      pin.last = 1'b1;
      drive_word(dir_tab[i].op, dir_tab[i].b, dir_tab[i].pinned, pin);
    end
    in_valid <= 1'b0;
    drain();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      // Reconfigure while idle, with a write to an unused index as well
      write_reg(REG_DELIM, {24'($urandom), phase_delim[ph]});
      write_reg(REG_LIMIT, phase_limit[ph]);
      write_reg(4'($urandom_range(REG_COUNT, 15)), $urandom);
      if (ph == 1) write_reg(4'd15, 32'hFFFF_FFFF);
      cfg_valid <= 1'b0;
      in_quiet = (ph == 2) || (ph == 5);
      out_quiet = (ph == 2) || (ph == 4);

      // Mostly well-formed CSV with random content, some raw noise
      n_sent = 0;
      while (n_sent < ITEMS_PER_PHASE) begin
        r = $urandom_range(0, 99);
        if (r < 6) begin
          drive_word(OP_FLUSH, 8'($urandom), 1'b0, '0);
          n_sent++;
          if ($urandom_range(0, 1) == 1) begin
            send_byte(BOM_A);
            n_sent++;
            if ($urandom_range(0, 3) != 0) begin
              send_byte(BOM_B);
              n_sent++;
              if ($urandom_range(0, 3) != 0) begin
                send_byte(BOM_C);
                n_sent++;
              end
            end
          end
        end else if (r < 18) begin
          send_byte(CH_QUOTE);
          k = $urandom_range(0, 4);
          for (int j = 0; j < k; j++) begin
            if ($urandom_range(0, 4) == 0) begin
              send_byte(CH_QUOTE);
              send_byte(CH_QUOTE);
              n_sent += 2;
            end else begin
              send_byte(noise_byte());
              n_sent++;
            end
          end
          send_byte(CH_QUOTE);
          n_sent += 2;
        end else if (r < 25) begin
          send_byte(CH_CR);
          send_byte(CH_LF);
          n_sent += 2;
        end else if (r < 40) begin
          send_byte(8'($urandom_range(0, 255)));
          n_sent++;
        end else begin
          send_byte(noise_byte());
          n_sent++;
        end
      end
      in_valid <= 1'b0;
      drain();
    end

    if (n_fail == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> csv_byte_tokenizer.f
+incdir+rtl/core
rtl/core/csvt_pkg.sv
rtl/core/csvt_front.sv
rtl/core/csvt_queue.sv
rtl/core/csvt_back.sv
rtl/core/csv_byte_tokenizer.sv
bench/tb_top.sv
